[rtl/cbts_pkg.sv]
// Package for the CAN bit timing search: payload structs, register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbts_pkg;
    typedef struct packed {
        logic [19:0] target_bitrate;
        logic [3:0]  jump_width_limit;
    } t_in_item;

    typedef struct packed {
        logic [10:0] prescaler;
        logic [7:0]  prop_segment;
        logic [8:0]  phase_one;
        logic [7:0]  phase_two;
        logic        jump_width;
        logic [31:0] rate_error;
        logic        exact_match;
    } t_out_item;

    localparam logic [2:0] REG_CLOCK    = 3'd0;
    localparam logic [2:0] REG_SEG1_MIN = 3'd1;
    localparam logic [2:0] REG_SEG1_MAX = 3'd2;
    localparam logic [2:0] REG_SEG2_MIN = 3'd3;
    localparam logic [2:0] REG_SEG2_MAX = 3'd4;
    localparam logic [2:0] REG_PRE_MIN  = 3'd5;
    localparam logic [2:0] REG_PRE_MAX  = 3'd6;
    localparam logic [2:0] REG_PRE_STEP = 3'd7;

    localparam int unsigned SAMPLE_TARGET = 875;
    localparam int unsigned PER_MILLE     = 1000;
endpackage
`default_nettype wire

[rtl/cbts_div.sv]
// Shared restoring divider, one quotient bit per cycle (32-bit / 32-bit).
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module cbts_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    logic [31:0] r_rem, r_quot, r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_trial;
    logic [32:0] w_sub;

    assign w_trial = {r_rem, r_quot[31]};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_sub[32]) begin
                r_rem  <= w_sub[31:0];
                r_quot <= {r_quot[30:0], 1'b1};
            end else begin
                r_rem  <= w_trial[31:0];
                r_quot <= {r_quot[30:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end
    assign o_quot = r_quot;
endmodule
`default_nettype wire

[rtl/can_bit_timing_search.sv]
// CAN bit timing search top level: config registers, search sequencer.
// Depends on cbts_pkg and cbts_div.
//
// channel | valid        | ready        | payload
// cfg     | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
// in      | i_in_valid   | o_in_ready   | i_in_data
// out     | o_out_valid  | i_out_ready  | o_out_data
//
// Each candidate passes S_SEG2, S_MUL, two divider launches and S_CMP, plus two
// waits on the single shared 32-step divider. Each seg1 value and each prescaler
// also pass through S_SEG1 and S_PRE; the result goes out from S_OUT.
// Reset is synchronous; no item is taken while a search runs or a result waits,
// and a config write offered in idle goes ahead of an input item.
`timescale 1ns / 1ps
`default_nettype none
module can_bit_timing_search (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [29:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire cbts_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output cbts_pkg::t_out_item     o_out_data
);
    import cbts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PRE, S_SEG1, S_SEG2, S_MUL, S_RDIV, S_RWAIT,
        S_SDIV, S_SWAIT, S_CMP, S_OUT
    } t_state;

    t_state      r_state;
    logic [29:0] r_clk_hz;
    logic [8:0]  r_s1_min, r_s1_max;
    logic [7:0]  r_s2_min, r_s2_max;
    logic [10:0] r_p_min, r_p_max, r_p_step;

    logic [19:0] r_target;
    logic        r_jump;
    logic [11:0] r_pre;
    logic [9:0]  r_s1;
    logic [8:0]  r_s2;
    logic [9:0]  r_quanta;
    logic [21:0] r_prod;
    logic [31:0] r_rate;
    logic [31:0] r_err;
    logic [9:0]  r_serr;
    logic [31:0] r_best_err;
    logic [9:0]  r_best_serr;
    logic        r_found;
    logic [10:0] r_b_pre;
    logic [8:0]  r_b_s1;
    logic [7:0]  r_b_s2;

    logic        r_dstart;
    logic [31:0] r_dnum, r_dden;
    logic        w_ddone;
    logic [31:0] w_dquot;

    cbts_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_dstart),
        .i_num  (r_dnum),
        .i_den  (r_dden),
        .o_done (w_ddone),
        .o_quot (w_dquot)
    );

    logic [11:0] w_step;
    logic [9:0]  w_serr_abs;
    logic [7:0]  w_prop;
    logic [8:0]  w_ph1;
    logic [8:0]  w_half;

    assign w_step = (r_p_step == '0) ? 12'd1 : {1'b0, r_p_step};
    assign w_serr_abs = (w_dquot[9:0] > 10'(SAMPLE_TARGET))
                      ? w_dquot[9:0] - 10'(SAMPLE_TARGET)
                      : 10'(SAMPLE_TARGET) - w_dquot[9:0];

    always_comb begin
        w_half = {1'b0, r_b_s1[8:1]};
        if (w_half == '0) w_half = 9'd1;
        if (r_b_s1 <= w_half) begin
            w_ph1  = 9'd1;
            w_prop = (r_b_s1 != '0) ? 8'(r_b_s1 - 9'd1) : 8'd0;
        end else begin
            w_ph1  = r_b_s1 - w_half;
            w_prop = w_half[7:0];
        end
    end

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;

    always_ff @(posedge i_clk) begin
        r_dstart <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_clk_hz    <= 30'd48000000;
            r_s1_min    <= 9'd1;
            r_s1_max    <= 9'd16;
            r_s2_min    <= 8'd1;
            r_s2_max    <= 8'd8;
            r_p_min     <= 11'd1;
            r_p_max     <= 11'd1024;
            r_p_step    <= 11'd1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        unique case (i_cfg_index)
                            REG_CLOCK:    r_clk_hz <= i_cfg_data;
                            REG_SEG1_MIN: r_s1_min <= i_cfg_data[8:0];
                            REG_SEG1_MAX: r_s1_max <= i_cfg_data[8:0];
                            REG_SEG2_MIN: r_s2_min <= i_cfg_data[7:0];
                            REG_SEG2_MAX: r_s2_max <= i_cfg_data[7:0];
                            REG_PRE_MIN:  r_p_min  <= i_cfg_data[10:0];
                            REG_PRE_MAX:  r_p_max  <= i_cfg_data[10:0];
                            REG_PRE_STEP: r_p_step <= i_cfg_data[10:0];
                            default: ;
                        endcase
                    end else if (i_in_valid) begin
                        r_target    <= i_in_data.target_bitrate;
                        r_jump      <= (i_in_data.jump_width_limit != '0);
                        r_pre       <= {1'b0, r_p_min};
                        r_found     <= 1'b0;
                        r_best_err  <= '1;
                        r_best_serr <= '1;
                        r_b_pre     <= '0;
                        r_b_s1      <= '0;
                        r_b_s2      <= '0;
                        r_state     <= S_PRE;
                    end
                end
                S_PRE: begin
                    if (r_pre > {1'b0, r_p_max}) begin
                        r_state <= S_OUT;
                    end else if (r_pre == '0) begin
                        r_pre <= r_pre + w_step;
                    end else begin
                        r_s1    <= {1'b0, r_s1_min};
                        r_state <= S_SEG1;
                    end
                end
                S_SEG1: begin
                    if (r_s1 > {1'b0, r_s1_max}) begin
                        r_pre   <= r_pre + w_step;
                        r_state <= S_PRE;
                    end else begin
                        r_s2    <= {1'b0, r_s2_min};
                        r_state <= S_SEG2;
                    end
                end
                S_SEG2: begin
                    if (r_s2 > {1'b0, r_s2_max}) begin
                        r_s1    <= r_s1 + 10'd1;
                        r_state <= S_SEG1;
                    end else begin
                        r_quanta <= 10'd1 + r_s1 + 10'(r_s2);
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= {11'b0, r_pre[10:0]} * {12'b0, r_quanta};
                    r_state <= S_RDIV;
                end
                S_RDIV: begin
                    r_dnum   <= {2'b0, r_clk_hz};
                    r_dden   <= {10'b0, r_prod};
                    r_dstart <= 1'b1;
                    r_state  <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (w_ddone) begin
                        r_rate  <= w_dquot;
                        r_state <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    r_err    <= (r_rate > {12'b0, r_target})
                              ? r_rate - {12'b0, r_target}
                              : {12'b0, r_target} - r_rate;
                    r_dnum   <= ({22'b0, r_s1} + 32'd1) * 32'(PER_MILLE);
                    r_dden   <= {22'b0, r_quanta};
                    r_dstart <= 1'b1;
                    r_state  <= S_SWAIT;
                end
                S_SWAIT: begin
                    if (w_ddone) begin
                        r_serr  <= w_serr_abs;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (!r_found || r_err < r_best_err ||
                        (r_err == r_best_err && r_serr < r_best_serr)) begin
                        r_found     <= 1'b1;
                        r_best_err  <= r_err;
                        r_best_serr <= r_serr;
                        r_b_pre     <= r_pre[10:0];
                        r_b_s1      <= r_s1[8:0];
                        r_b_s2      <= r_s2[7:0];
                    end
                    r_s2    <= r_s2 + 9'd1;
                    r_state <= S_SEG2;
                end
                S_OUT: begin
                    if (!o_out_valid) begin
                        o_out_valid <= 1'b1;
                        o_out_data.prescaler    <= r_b_pre;
                        o_out_data.prop_segment <= r_found ? w_prop : 8'd0;
                        o_out_data.phase_one    <= r_found ? w_ph1 : 9'd0;
                        o_out_data.phase_two    <= r_b_s2;
                        o_out_data.jump_width   <= r_found & r_jump;
                        o_out_data.rate_error   <= r_best_err;
                        o_out_data.exact_match  <= r_found && (r_best_err == '0);
                    end else if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_in_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");
    a_exact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.exact_match) |-> (o_out_data.rate_error == '0))
        else $error("exact flag with nonzero error");
    a_div_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dstart |-> (r_state == S_RWAIT || r_state == S_SWAIT))
        else $error("divider started outside search");
endmodule
`default_nettype wire
